FILE: hdl/s1sh_pkg.sv
// s1sh_pkg: shared types, constants and round helpers for the SHA-1 stream hasher.
// No dependencies.
package s1sh_pkg;
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hefcdab89;
	localparam logic [31:0] H2 = 32'h98badcfe;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hc3d2e1f0;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int QDEPTH = 4;

	typedef enum logic {OP_ABSORB = 1'b0, OP_FINISH = 1'b1} op_t;

	// item passed from front to back
	typedef struct packed {
		op_t op;
		logic [7:0] data;
	} qitem_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_PADFILL, BK_LEN, BK_ROUND, BK_EMIT
	} bk_state_t;

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		rol = (x << n) | (x >> (32 - n));
	endfunction
endpackage

FILE: hdl/s1sh_front.sv
// s1sh_front: input acceptance and item queue between ports and the hash engine.
// Depends on s1sh_pkg.
module s1sh_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_op,
	input logic [7:0] in_data,
	output logic q_valid,
	input logic q_ready,
	output s1sh_pkg::qitem_t q_item
);
	import s1sh_pkg::*;

	qitem_t mem_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(QDEPTH):0] cnt_q;
	logic push, pop;

	// classify item and push to queue
	assign in_ready = (cnt_q != QDEPTH[$clog2(QDEPTH):0]);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{op: op_t'(in_op), data: in_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
		end
	end
endmodule

FILE: hdl/s1sh_back.sv
// s1sh_back: block buffer, padding, 80-round compression and digest emit.
// Depends on s1sh_pkg.
module s1sh_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input s1sh_pkg::qitem_t q_item,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word
);
	import s1sh_pkg::*;

	bk_state_t state_q, state_d;
	// 16-word sliding schedule window; bytes shift in at word 15
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [63:0] cnt_q, len_q;
	logic [5:0] pos_q;
	logic [6:0] rnd_q;
	logic [2:0] len_idx_q;
	logic [2:0] widx_q;
	logic fin_q;

	logic take, shift_en, fill_done;
	logic [7:0] shift_byte;
	logic [31:0] f, k, t, wnew, wrnd;
	logic [31:0] dw [5];

	// next-state and handshake
	always_comb begin
		state_d = state_q;
		take = 1'b0;
		shift_en = 1'b0;
		shift_byte = q_item.data;
		q_ready = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					take = 1'b1;
					shift_en = 1'b1;
					if (q_item.op == OP_FINISH) begin
						shift_byte = PAD_BYTE;
						if (pos_q == 6'd63) state_d = BK_ROUND;
						else if (pos_q == 6'd55) state_d = BK_LEN;
						else state_d = BK_PADFILL;
					end else if (pos_q == 6'd63) begin
						state_d = BK_ROUND;
					end
				end
			end
			BK_PADFILL: begin
				shift_en = 1'b1;
				shift_byte = 8'h00;
				if (pos_q == 6'd63) state_d = BK_ROUND;
				else if (pos_q == 6'd55) state_d = BK_LEN;
			end
			BK_LEN: begin
				shift_en = 1'b1;
				shift_byte = len_q[63 - 8*len_idx_q -: 8];
				if (pos_q == 6'd63) state_d = BK_ROUND;
			end
			BK_ROUND: begin
				if (rnd_q == 7'd80) begin
					if (!fin_q) state_d = BK_IDLE;
					else if (fill_done) state_d = BK_EMIT;
					else if (pos_q == 6'd56) state_d = BK_LEN;
					else state_d = BK_PADFILL;
				end
			end
			BK_EMIT: begin
				if (out_ready && widx_q == 3'd4) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// fill_done: length already placed in the block just compressed
	logic lenin_q;
	assign fill_done = lenin_q;

	// round function
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
		wnew = rol(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		wrnd = w_q[0];
		t = rol(a_q, 5) + f + e_q + wrnd + k;
	end

	always_comb begin
		for (int i = 0; i < 5; i++) dw[i] = h_q[i];
	end

	assign out_valid = (state_q == BK_EMIT);
	assign digest_word = dw[widx_q];
	assign word_index = widx_q;
	assign last_word = (widx_q == 3'd4);

	// schedule window and working registers
	always_ff @(posedge clk) begin
		if (shift_en) begin
			// align: words shift once per 4 bytes
			if (pos_q[1:0] == 2'd0) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			end
			w_q[15] <= {w_q[15][23:0], shift_byte};
		end else if (state_q == BK_ROUND && rnd_q != 7'd80) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
			e_q <= d_q; d_q <= c_q; c_q <= rol(b_q, 30); b_q <= a_q; a_q <= t;
		end
		if (state_d == BK_ROUND && state_q != BK_ROUND) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			h_q <= '{H0, H1, H2, H3, H4};
			cnt_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			rnd_q <= '0;
			len_idx_q <= '0;
			widx_q <= '0;
			fin_q <= 1'b0;
			lenin_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take && q_item.op == OP_ABSORB) cnt_q <= cnt_q + 64'd8;
			if (take && q_item.op == OP_FINISH) begin
				fin_q <= 1'b1;
				len_q <= cnt_q;
				lenin_q <= 1'b0;
			end
			if (shift_en) pos_q <= pos_q + 1'b1;
			if (state_q == BK_LEN) begin
				len_idx_q <= len_idx_q + 1'b1;
				if (len_idx_q == 3'd7) lenin_q <= 1'b1;
			end
			if (state_q == BK_ROUND) begin
				if (rnd_q == 7'd80) begin
					rnd_q <= '0;
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end else begin
					rnd_q <= rnd_q + 1'b1;
				end
			end
			if (state_q == BK_EMIT && out_ready) begin
				if (widx_q == 3'd4) begin
					widx_q <= '0;
					h_q <= '{H0, H1, H2, H3, H4};
					cnt_q <= '0;
					pos_q <= '0;
					fin_q <= 1'b0;
					lenin_q <= 1'b0;
					len_idx_q <= '0;
				end else begin
					widx_q <= widx_q + 1'b1;
				end
			end
		end
	end
endmodule

FILE: hdl/sha1_stream_hasher.sv
// sha1_stream_hasher: top level of the byte-serial SHA-1 hasher.
// Depends on s1sh_pkg, s1sh_front, s1sh_back.
//
//   channel | signals                               | direction
//   in      | in_valid/in_ready, op, data_byte      | item in
//   out     | out_valid/out_ready, digest_word,     | item out
//           | word_index, last_word                 |
//
// Every 64th absorbed byte starts a compression (one round per cycle in the back
// engine). Finish takes any zero fill and the length, one or two compressions, then
// five output items, each held while out_ready is low. A 4-item queue lets input be
// taken while the engine works; in_ready drops only when it is full. Reset returns
// to the SHA-1 initial values.
module sha1_stream_hasher (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic [7:0] data_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic last_word
);
	import s1sh_pkg::*;

	logic q_valid, q_ready;
	qitem_t q_item;

	s1sh_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_op(op), .in_data(data_byte),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
	);

	s1sh_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);
endmodule

FILE: tb/tb_sha1_stream_hasher.sv
// tb_sha1_stream_hasher: self-checking testbench for the byte-serial SHA-1 hasher.
// Depends on s1sh_pkg and sha1_stream_hasher; digests come from a local SHA-1 predictor.
module tb_sha1_stream_hasher;
	import s1sh_pkg::*;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0] idx;
		logic last;
	} digest_item_t;

	typedef struct packed {
		op_t op;
		logic [7:0] data;
		logic has_exp;
		logic [31:0] exp_w0;
	} stim_row_t;

	localparam int LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic op;
	logic [7:0] data_byte;
	logic out_valid;
	logic out_ready;
	logic [31:0] digest_word;
	logic [2:0] word_index;
	logic last_word;

	// predictor state
	logic [31:0] chain[5];
	logic [7:0] blk[64];
	logic [63:0] nbits;

	digest_item_t digest_q[$];
	int errors;
	int cycles;
	bit quiet_tail;
	logic [31:0] pinned_w0[$];

	sha1_stream_hasher DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// one 80-round compression over blk
	task automatic sha1_compress();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = K0;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = K2;
			end else begin
				f = b ^ c ^ d; k = K3;
			end
			t = rotl(a, 5) + f + e + w[i] + k;
			e = d; d = c; c = rotl(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	task automatic hash_init();
		chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
		nbits = '0;
		for (int i = 0; i < 64; i++) blk[i] = '0;
	endtask

	// advance the predictor by one accepted item
	task automatic hash_step(input op_t o, input logic [7:0] d);
		int pos;
		logic [63:0] len;
		digest_item_t r;
		pos = nbits[8:3];
		if (o == OP_ABSORB) begin
			blk[pos] = d;
			nbits += 64'd8;
			if (pos == 63) sha1_compress();
		end else begin
			len = nbits;
			blk[pos] = PAD_BYTE;
			pos = pos + 1;
			if (pos > 56) begin
				while (pos < 64) begin
					blk[pos] = '0;
					pos = pos + 1;
				end
				sha1_compress();
				pos = 0;
			end
			while (pos < 56) begin
				blk[pos] = '0;
				pos = pos + 1;
			end
			for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
			sha1_compress();
			for (int i = 0; i < 5; i++) begin
				r.word = chain[i]; r.idx = i[2:0]; r.last = (i == 4);
				digest_q.push_back(r);
			end
			hash_init();
		end
	endtask

	// send one item; random idle bursts before it
	task automatic send_item(input op_t o, input logic [7:0] d);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		data_byte <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		hash_step(o, d);
		@(negedge clk);
	endtask

	task automatic send_message(input int n);
		for (int i = 0; i < n; i++) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
		send_item(OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// receiver: random stall bursts, compare each word with oldest expectation
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		digest_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest word %h idx %0d", $time, digest_word,
					word_index);
				errors++;
			end else begin
				e = digest_q.pop_front();
				if (e.idx == 0 && pinned_w0.size() > 0) begin
					// directed rows with a known first word
					if (pinned_w0[0] !== digest_word) begin
						$display("%0t: known digest word0 exp %h act %h", $time,
							pinned_w0[0], digest_word);
						errors++;
					end
					void'(pinned_w0.pop_front());
				end
				if (e.word !== digest_word) begin
					$display("%0t: digest_word exp %h act %h", $time, e.word, digest_word);
					errors++;
				end
				if (e.idx !== word_index) begin
					$display("%0t: word_index exp %0d act %0d", $time, e.idx, word_index);
					errors++;
				end
				if (e.last !== last_word) begin
					$display("%0t: last_word exp %b act %b", $time, e.last, last_word);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_sha1_stream_hasher failed");
			$finish;
		end
	end

	stim_row_t dir_rows[$];

	initial begin
		stim_row_t row;
		int n;
		errors = 0;
		cycles = 0;
		quiet_tail = 1'b0;
		in_valid = 1'b0;
		op = OP_ABSORB;
		data_byte = '0;
		arst_n = 1'b0;
		hash_init();
		// directed table: empty message (known digest), "abc", extreme bytes
		dir_rows.push_back('{OP_FINISH, 8'hff, 1'b1, 32'hda39a3ee});
		dir_rows.push_back('{OP_ABSORB, 8'h61, 1'b0, '0});
		dir_rows.push_back('{OP_ABSORB, 8'h62, 1'b0, '0});
		dir_rows.push_back('{OP_ABSORB, 8'h63, 1'b0, '0});
		dir_rows.push_back('{OP_FINISH, 8'h00, 1'b1, 32'ha9993e36});
		dir_rows.push_back('{OP_ABSORB, 8'h00, 1'b0, '0});
		dir_rows.push_back('{OP_ABSORB, 8'hff, 1'b0, '0});
		dir_rows.push_back('{OP_ABSORB, 8'haa, 1'b0, '0});
		dir_rows.push_back('{OP_ABSORB, 8'h55, 1'b0, '0});
		dir_rows.push_back('{OP_FINISH, 8'h00, 1'b0, '0});
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.has_exp) pinned_w0.push_back(row.exp_w0);
			send_item(row.op, row.data);
		end
		// pad boundary lengths: 55 fits, 56 spills, 127 fills a block then pads at 63
		send_message(55);
		send_message(56);
		// sender holds off until all digests are back
		in_valid <= 1'b0;
		do @(negedge clk); while (digest_q.size() != 0);
		send_message(127);

		// random short messages, the last ones with no idling
		n = 0;
		while (n < 12) begin
			int len;
			len = $urandom_range(0, 5);
			if (n > 5) quiet_tail = 1'b1;
			send_message(len);
			n += len + 1;
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (digest_q.size() != 0);
		repeat (300) @(negedge clk);
		if (errors == 0)
			$display("tb_sha1_stream_hasher passed");
		else
			$display("tb_sha1_stream_hasher failed");
		$finish;
	end
endmodule
